### design/phase_to_sine_cosine_macros.svh
// assertion macros for the phase to sine/cosine block
// no dependencies; included by files that carry concurrent checks
`ifndef PHASE_TO_SINE_COSINE_MACROS_SVH
`define PHASE_TO_SINE_COSINE_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define P2SC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define P2SC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define P2SC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define P2SC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/p2sc_pkg.sv
// shared types, fixed-point constants and rounding helper for the sine/cosine pipeline
// no dependencies
package p2sc_pkg;

    localparam int PHASE_BITS_DEF = 24;
    localparam int OUT_BITS_DEF   = 16;

    // polynomial values are unsigned q30 held in 31 bits so that 1.0 fits
    localparam int FRAC   = 30;
    localparam int VAL_W  = 31;
    localparam int PROD_W = 2 * VAL_W;

    // pi in q32, split in two halves for the angle scaling multiply
    localparam int             PI_W     = 34;
    localparam int             PI_SPLIT = 17;
    localparam logic [PI_W-1:0] PI_Q32  = 34'h3243F6A89;
    localparam logic [PI_W-PI_SPLIT-1:0] PI_HI = PI_Q32[PI_W-1:PI_SPLIT];
    localparam logic [PI_SPLIT-1:0]      PI_LO = PI_Q32[PI_SPLIT-1:0];

    localparam logic [VAL_W-1:0] ONE_Q30 = 31'h40000000;
    localparam logic [VAL_W-1:0] S3  = 31'd178956971;
    localparam logic [VAL_W-1:0] S5  = 31'd8947849;
    localparam logic [VAL_W-1:0] S7  = 31'd213044;
    localparam logic [VAL_W-1:0] S9  = 31'd2959;
    localparam logic [VAL_W-1:0] C2  = 31'd536870912;
    localparam logic [VAL_W-1:0] C4  = 31'd44739243;
    localparam logic [VAL_W-1:0] C6  = 31'd1491308;
    localparam logic [VAL_W-1:0] C8  = 31'd26631;
    localparam logic [VAL_W-1:0] C10 = 31'd296;

    // horner steps; the last sine step multiplies by the angle and subtracts nothing
    localparam int NSTEPS = 5;
    localparam logic [VAL_W-1:0] SIN_INIT = S9;
    localparam logic [VAL_W-1:0] COS_INIT = C10;
    localparam logic [VAL_W-1:0] SIN_COEF [NSTEPS] = '{S7, S5, S3, ONE_Q30, 31'd0};
    localparam logic [VAL_W-1:0] COS_COEF [NSTEPS] = '{C8, C6, C4, C2, ONE_Q30};

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (FRAC - 1);

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        logic  valid;
        logic  swap;
        t_quad quad;
    } t_ctrl;

    typedef struct packed {
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] t;
    } t_ops;

    // q30 product back to q30, rounding half up
    function automatic logic [VAL_W-1:0] qround(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + ROUND_HALF;
        return s[FRAC+VAL_W-1:FRAC];
    endfunction

endpackage

### design/p2sc_channels.sv
// handshake channel interfaces for phase items and sine/cosine result items
// depends on p2sc_pkg
interface p2sc_phase_if
    import p2sc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PHASE_BITS-1:0] phase;

    modport source (output valid, output phase, input ready);
    modport sink   (input valid, input phase, output ready);
endinterface

interface p2sc_result_if
    import p2sc_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] sine;
    logic signed [OUT_BITS-1:0] cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

### design/p2sc_angle.sv
// front stages: octant fold, scaling to a q30 angle, squaring of the angle
// depends on p2sc_pkg
module p2sc_angle
    import p2sc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [PHASE_BITS-1:0] i_phase,
    output t_ctrl                 o_ctrl,
    output t_ops                  o_ops
);
    localparam int ZW  = PHASE_BITS - 2;
    localparam int PHW = ZW + PI_W - PI_SPLIT;
    localparam int PLW = ZW + PI_SPLIT;
    localparam int SW  = ZW + PI_W + 1;
    localparam logic [ZW-1:0] HALF = ZW'(1) << (ZW - 1);
    localparam logic [SW-1:0] RND  = SW'(1) << PHASE_BITS;

    t_ctrl            n_a_ctrl, r_a_ctrl, r_b_ctrl, r_c_ctrl, r_d_ctrl, r_e_ctrl;
    logic [ZW-1:0]    w_r, n_z, r_z;
    logic [PHW-1:0]   r_b_hi;
    logic [PLW-1:0]   r_b_lo;
    logic [SW-1:0]    n_sum;
    logic [VAL_W-1:0] r_c_a, r_d_a, r_e_a, r_e_t;
    logic [PROD_W-1:0] r_d_sq;

    assign w_r = i_phase[ZW-1:0];

    always_comb begin
        n_a_ctrl.valid = i_valid;
        n_a_ctrl.quad  = t_quad'(i_phase[PHASE_BITS-1 -: 2]);
        n_a_ctrl.swap  = (w_r > HALF);
        // quarter minus r equals minus r modulo the quarter, r being nonzero here
        n_z = n_a_ctrl.swap ? ZW'(0) - w_r : w_r;
    end

    assign n_sum = (SW'(r_b_hi) << PI_SPLIT) + SW'(r_b_lo) + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl.valid <= 1'b0;
            r_b_ctrl.valid <= 1'b0;
            r_c_ctrl.valid <= 1'b0;
            r_d_ctrl.valid <= 1'b0;
            r_e_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_a_ctrl <= n_a_ctrl;
            r_b_ctrl <= r_a_ctrl;
            r_c_ctrl <= r_b_ctrl;
            r_d_ctrl <= r_c_ctrl;
            r_e_ctrl <= r_d_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z    <= n_z;
            r_b_hi <= PHW'(r_z) * PHW'(PI_HI);
            r_b_lo <= PLW'(r_z) * PLW'(PI_LO);
            r_c_a  <= n_sum[PHASE_BITS+VAL_W:PHASE_BITS+1];
            r_d_a  <= r_c_a;
            r_d_sq <= PROD_W'(r_c_a) * PROD_W'(r_c_a);
            r_e_a  <= r_d_a;
            r_e_t  <= qround(r_d_sq);
        end
    end

    assign o_ctrl = r_e_ctrl;
    assign o_ops  = '{a: r_e_a, t: r_e_t};

endmodule

### design/p2sc_hstep.sv
// one horner step for both polynomials: multiply stage, then round and subtract stage
// depends on p2sc_pkg
module p2sc_hstep
    import p2sc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctrl            i_ctrl,
    input  t_ops             i_ops,
    input  logic [VAL_W-1:0] i_sin,
    input  logic [VAL_W-1:0] i_cos,
    output t_ctrl            o_ctrl,
    output t_ops             o_ops,
    output logic [VAL_W-1:0] o_sin,
    output logic [VAL_W-1:0] o_cos
);
    localparam bit SIN_LAST = (STEP == NSTEPS - 1);
    localparam logic [VAL_W-1:0] K_SIN = SIN_COEF[STEP];
    localparam logic [VAL_W-1:0] K_COS = COS_COEF[STEP];

    t_ctrl             r_m_ctrl, r_ctrl;
    t_ops              r_m_ops, r_ops;
    logic [PROD_W-1:0] r_m_ps, r_m_pc;
    logic [VAL_W-1:0]  w_mul_s, n_sin, n_cos, r_sin, r_cos;

    // the final sine step multiplies by the angle instead of its square
    assign w_mul_s = SIN_LAST ? i_ops.a : i_ops.t;

    always_comb begin
        n_sin = SIN_LAST ? qround(r_m_ps) : K_SIN - qround(r_m_ps);
        n_cos = K_COS - qround(r_m_pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctrl.valid <= 1'b0;
            r_ctrl.valid   <= 1'b0;
        end else if (i_en) begin
            r_m_ctrl <= i_ctrl;
            r_ctrl   <= r_m_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_ops <= i_ops;
            r_m_ps  <= PROD_W'(w_mul_s) * PROD_W'(i_sin);
            r_m_pc  <= PROD_W'(i_ops.t) * PROD_W'(i_cos);
            r_ops   <= r_m_ops;
            r_sin   <= n_sin;
            r_cos   <= n_cos;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_ops  = r_ops;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

### design/p2sc_obuf.sv
// two-entry output buffer that decouples the pipeline from the result channel
// depends on p2sc_pkg and p2sc_result_if
module p2sc_obuf
    import p2sc_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [OUT_BITS-1:0] i_sine,
    input  logic signed [OUT_BITS-1:0] i_cosine,
    output logic                       o_full,
    p2sc_result_if.source              o_result
);
    logic [1:0]                 r_cnt, n_cnt;
    logic signed [OUT_BITS-1:0] r_head_s, r_head_c, r_spare_s, r_spare_c;
    logic                       w_pop;

    assign w_pop = o_result.valid && o_result.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_head_s <= r_spare_s;
                r_head_c <= r_spare_c;
            end else if (i_push) begin
                r_head_s <= i_sine;
                r_head_c <= i_cosine;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_head_s <= i_sine;
                r_head_c <= i_cosine;
            end else begin
                r_spare_s <= i_sine;
                r_spare_c <= i_cosine;
            end
        end
    end

    assign o_full          = (r_cnt == 2'd2);
    assign o_result.valid  = (r_cnt != 2'd0);
    assign o_result.sine   = r_head_s;
    assign o_result.cosine = r_head_c;

endmodule

### design/phase_to_sine_cosine.sv
// Phase to sine/cosine: takes an unsigned phase word covering one full turn and returns
// sin and cos of the phase as signed fixed-point values saturated to plus or minus full
// scale. The block accepts one item every cycle unless the output buffer is full. The depth
// is set by the five Horner steps of the polynomial core, each a registered multiply
// followed by a registered round and subtract, behind the fold, angle scaling and squaring
// stages, before the output stages. A two-entry output buffer lets the pipeline keep taking
// items while one result waits; when both entries are held the whole pipeline holds.
// depends on p2sc_pkg, p2sc_channels, p2sc_angle, p2sc_hstep, p2sc_obuf and the macros header
`include "phase_to_sine_cosine_macros.svh"

module phase_to_sine_cosine
    import p2sc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int OUT_BITS   = OUT_BITS_DEF
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    p2sc_phase_if.sink    i_phase,
    p2sc_result_if.source o_result
);
    localparam logic [VAL_W:0]    RND_OUT = (VAL_W+1)'(1) << (FRAC - OUT_BITS);
    localparam logic [VAL_W:0]    TOP_W   = (VAL_W+1)'({(OUT_BITS-1){1'b1}});
    localparam logic [OUT_BITS-2:0] TOP_M = {(OUT_BITS-1){1'b1}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    t_ctrl            w_ctrl [NSTEPS+1];
    t_ops             w_ops  [NSTEPS+1];
    logic [VAL_W-1:0] w_sin  [NSTEPS+1];
    logic [VAL_W-1:0] w_cos  [NSTEPS+1];
    logic             w_en, w_full;

    t_ctrl                      r_s1_ctrl, r_s2_ctrl;
    logic [OUT_BITS-2:0]        r_s1_ss, r_s1_cc;
    logic [OUT_BITS-1:0]        w_pos_s, w_pos_c, w_neg_s, w_neg_c;
    logic signed [OUT_BITS-1:0] n_s2_sine, n_s2_cos, r_s2_sine, r_s2_cos;

    // magnitude in the output format, rounded and saturated at full scale
    function automatic logic [OUT_BITS-2:0] to_mag(input logic [VAL_W-1:0] v);
        logic [VAL_W:0] s;
        logic [VAL_W:0] m;
        s = {1'b0, v} + RND_OUT;
        m = s >> (VAL_W - OUT_BITS);
        return (m > TOP_W) ? TOP_M : m[OUT_BITS-2:0];
    endfunction

    assign w_en          = !w_full;
    assign i_phase.ready = w_en;

    p2sc_angle #(
        .PHASE_BITS (PHASE_BITS)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_phase.valid),
        .i_phase (i_phase.phase[PHASE_BITS-1:0]),
        .o_ctrl  (w_ctrl[0]),
        .o_ops   (w_ops[0])
    );

    assign w_sin[0] = SIN_INIT;
    assign w_cos[0] = COS_INIT;

    for (genvar k = 0; k < NSTEPS; k++) begin : g_step
        p2sc_hstep #(
            .STEP (k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[k]),
            .i_ops   (w_ops[k]),
            .i_sin   (w_sin[k]),
            .i_cos   (w_cos[k]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_ops   (w_ops[k+1]),
            .o_sin   (w_sin[k+1]),
            .o_cos   (w_cos[k+1])
        );
    end

    // swap back when folded, then apply the quadrant's signs and exchange in quadrants II and IV
    always_comb begin
        w_pos_s = r_s1_ctrl.swap ? {1'b0, r_s1_cc} : {1'b0, r_s1_ss};
        w_pos_c = r_s1_ctrl.swap ? {1'b0, r_s1_ss} : {1'b0, r_s1_cc};
        w_neg_s = OUT_BITS'(0) - w_pos_s;
        w_neg_c = OUT_BITS'(0) - w_pos_c;
        unique case (r_s1_ctrl.quad)
            QUAD_I: begin
                n_s2_sine = w_pos_s;
                n_s2_cos  = w_pos_c;
            end
            QUAD_II: begin
                n_s2_sine = w_pos_c;
                n_s2_cos  = w_neg_s;
            end
            QUAD_III: begin
                n_s2_sine = w_neg_s;
                n_s2_cos  = w_neg_c;
            end
            default: begin
                n_s2_sine = w_neg_c;
                n_s2_cos  = w_pos_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl.valid <= 1'b0;
            r_s2_ctrl.valid <= 1'b0;
        end else if (w_en) begin
            r_s1_ctrl <= w_ctrl[NSTEPS];
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ss   <= to_mag(w_sin[NSTEPS]);
            r_s1_cc   <= to_mag(w_cos[NSTEPS]);
            r_s2_sine <= n_s2_sine;
            r_s2_cos  <= n_s2_cos;
        end
    end

    p2sc_obuf #(
        .OUT_BITS (OUT_BITS)
    ) u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_en && r_s2_ctrl.valid),
        .i_sine   (r_s2_sine),
        .i_cosine (r_s2_cos),
        .o_full   (w_full),
        .o_result (o_result)
    );

    `P2SC_ASSERT_IMP(a_quad_i_nonneg, i_clk, i_rst_n,
        r_s2_ctrl.valid && r_s2_ctrl.quad == QUAD_I,
        !r_s2_sine[OUT_BITS-1] && !r_s2_cos[OUT_BITS-1])
    `P2SC_ASSERT_IMP(a_quad_iii_nonpos, i_clk, i_rst_n,
        r_s2_ctrl.valid && r_s2_ctrl.quad == QUAD_III,
        (r_s2_sine[OUT_BITS-1] || r_s2_sine == '0) && (r_s2_cos[OUT_BITS-1] || r_s2_cos == '0))
    `P2SC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        !w_en && r_s2_ctrl.valid,
        r_s2_ctrl.valid && $stable(r_s2_sine) && $stable(r_s2_cos))
    `P2SC_ASSERT_IMP(a_no_neg_full_scale, i_clk, i_rst_n,
        o_result.valid, o_result.sine != OUT_MIN && o_result.cosine != OUT_MIN)

endmodule
